// ===== rtl/taylor_sine_cosine_top_defines.svh =====
// Assertion macros shared by the taylor_sine_cosine RTL files.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef TAYLOR_SINE_COSINE_TOP_DEFINES_SVH
`define TAYLOR_SINE_COSINE_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TSC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("taylor_sine_cosine: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TSC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("taylor_sine_cosine: next-cycle check failed");

`endif

// ===== rtl/tsc_pkg.sv =====
// Package for the Taylor sine/cosine block: widths, reciprocal table, helpers.
// No dependencies; used by tsc_mul and taylor_sine_cosine_top.
`default_nettype none

package tsc_pkg;

	localparam int MAX_TERMS   = 16;
	localparam int FRAC_BITS   = 24;
	localparam int ANGLE_W     = 5;
	localparam int CNT_W       = 4;
	localparam int XMAG_W      = 5;
	localparam int X2_W        = 9;
	localparam int RES_W       = 37;
	localparam int MAG_W       = 45;
	localparam int SUM_W       = 50;
	localparam int K_W         = 5;
	localparam int D_W         = 10;
	localparam int DIGIT_W     = 8;
	localparam int NUM_DIGITS  = 7;
	localparam int DIG_IDX_W   = 3;
	localparam int DIV_W       = NUM_DIGITS * DIGIT_W;
	localparam int RP_W        = D_W + DIGIT_W;
	localparam int MUL_W       = 28;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = 28;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 40;

	typedef logic [MUL_W-1:0]   mul_op_t;
	typedef logic [PROD_W-1:0]  mul_prod_t;
	typedef logic [RECIP_W-1:0] recip_t;

	localparam longint RECIP_ONE = 64'sd1 << RECIP_SHIFT;

	// Rounded-up reciprocal of k(k+1), scaled by 2^RECIP_SHIFT, indexed by k.
	// Entries for k of zero and 31 are never used.
	localparam recip_t RECIP_TAB [32] = '{
		recip_t'(0),
		recip_t'((RECIP_ONE + 2 - 1) / 2),
		recip_t'((RECIP_ONE + 6 - 1) / 6),
		recip_t'((RECIP_ONE + 12 - 1) / 12),
		recip_t'((RECIP_ONE + 20 - 1) / 20),
		recip_t'((RECIP_ONE + 30 - 1) / 30),
		recip_t'((RECIP_ONE + 42 - 1) / 42),
		recip_t'((RECIP_ONE + 56 - 1) / 56),
		recip_t'((RECIP_ONE + 72 - 1) / 72),
		recip_t'((RECIP_ONE + 90 - 1) / 90),
		recip_t'((RECIP_ONE + 110 - 1) / 110),
		recip_t'((RECIP_ONE + 132 - 1) / 132),
		recip_t'((RECIP_ONE + 156 - 1) / 156),
		recip_t'((RECIP_ONE + 182 - 1) / 182),
		recip_t'((RECIP_ONE + 210 - 1) / 210),
		recip_t'((RECIP_ONE + 240 - 1) / 240),
		recip_t'((RECIP_ONE + 272 - 1) / 272),
		recip_t'((RECIP_ONE + 306 - 1) / 306),
		recip_t'((RECIP_ONE + 342 - 1) / 342),
		recip_t'((RECIP_ONE + 380 - 1) / 380),
		recip_t'((RECIP_ONE + 420 - 1) / 420),
		recip_t'((RECIP_ONE + 462 - 1) / 462),
		recip_t'((RECIP_ONE + 506 - 1) / 506),
		recip_t'((RECIP_ONE + 552 - 1) / 552),
		recip_t'((RECIP_ONE + 600 - 1) / 600),
		recip_t'((RECIP_ONE + 650 - 1) / 650),
		recip_t'((RECIP_ONE + 702 - 1) / 702),
		recip_t'((RECIP_ONE + 756 - 1) / 756),
		recip_t'((RECIP_ONE + 812 - 1) / 812),
		recip_t'((RECIP_ONE + 870 - 1) / 870),
		recip_t'((RECIP_ONE + 930 - 1) / 930),
		recip_t'(0)
	};

	// Divisor k(k+1) of the term recurrence.
	function automatic logic [D_W-1:0] tsc_den(input logic [K_W-1:0] k);
		logic [K_W:0] k1;
		k1 = {1'b0, k} + 1'b1;
		return D_W'(k * k1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tsc_mul.sv =====
// Shared unsigned multiplier of the Taylor sine/cosine block, product registered.
// Depends on tsc_pkg for operand and product widths.
`default_nettype none

module tsc_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tsc_pkg::mul_op_t  a,
	input  wire tsc_pkg::mul_op_t  b,
	output tsc_pkg::mul_prod_t     p
);
	import tsc_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p <= '0;
		end else begin
			p <= PROD_W'(a) * PROD_W'(b);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/taylor_sine_cosine_top.sv =====
// Top level of the Taylor sine/cosine block: sequencer, accumulator, output register.
// Depends on tsc_pkg, tsc_mul and taylor_sine_cosine_top_defines.svh.
//
// Usage. A request enters on the s_ stream: s_tuser selects the series (0 sine,
// 1 cosine), s_tdata carries the integer angle in radians and the index n of the
// last term summed. One result leaves on the m_ stream: m_tdata is the partial
// sum in two's complement with 24 fraction bits, and m_tuser flags a sum that
// was clamped to the 37-bit range.
// Sequence. After acceptance, each term after the first goes through the one
// shared 28x28 multiplier: two partial products for the term times x^2, then
// seven radix-256 digit steps of a reciprocal divide by k(k+1), two multiplies
// per digit, and an accumulate step; the final sum then goes to the output register.
// Flow. One request at a time; s_tready is high only while the sequencer is
// idle, so a new request is taken only once the previous one has finished. A
// finished result sits in the output register, so the next request is taken
// while that result waits for m_tready.
// Stall. If the receiver holds m_tready low and a second result completes, the
// sequencer waits in its final state until the output register empties.
// Reset. arst_n clears the sequencer, the datapath and the output valid flag at once.
`default_nettype none
`include "taylor_sine_cosine_top_defines.svh"

module taylor_sine_cosine_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// Fields from bit 0: angle[4:0], term_count[8:5], zero fill to 16 bits.
	input  wire logic [tsc_pkg::IN_DATA_W-1:0]   s_tdata,
	// Fields from bit 0: op (0 sine, 1 cosine).
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// Fields from bit 0: result[36:0], zero fill to 40 bits.
	output logic [tsc_pkg::OUT_DATA_W-1:0]       m_tdata,
	// Fields from bit 0: saturated.
	output logic                                 m_tuser
);
	import tsc_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		SETUP,
		MHI,
		MSUM,
		DQ,
		DR,
		ACC,
		DONE
	} state_t;

	localparam logic signed [SUM_W-1:0] RES_MAX_S = (SUM_W'(1) <<< (RES_W - 1)) - 1;
	localparam logic signed [SUM_W-1:0] RES_MIN_S = -(SUM_W'(1) <<< (RES_W - 1));

	state_t                     state_q;
	logic                       cosine_q;
	logic [X2_W-1:0]            x2_q;
	logic [MAG_W-1:0]           mag_q;
	logic                       neg_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           i_q;
	logic [CNT_W-1:0]           n_q;
	logic [D_W-1:0]             d_q;
	recip_t                     recip_q;
	mul_prod_t                  plo_q;
	logic [DIV_W-1:0]           div_q;
	logic [DIV_W-1:0]           quo_q;
	logic [DIG_IDX_W-1:0]       dig_q;
	logic                       first_q;
	logic [RP_W-1:0]            rprime_q;
	logic                       m_valid_q;
	logic [RES_W-1:0]           res_q;
	logic                       sat_q;

	mul_op_t                    mul_a;
	mul_op_t                    mul_b;
	mul_prod_t                  mul_p;

	logic                       s_accept;
	logic signed [ANGLE_W-1:0]  angle_in;
	logic [CNT_W-1:0]           cnt_in;
	logic [CNT_W-1:0]           n_in;
	logic                       xneg_in;
	logic [XMAG_W-1:0]          xmag_in;
	logic [K_W-1:0]             k_w;
	logic [D_W-1:0]             rem_w;
	logic [RP_W-1:0]            rprime_w;
	logic [DIGIT_W-1:0]         qd_w;
	logic [MAG_W-1:0]           mag_new;
	logic                       sum_hi;
	logic                       sum_lo;
	logic [RES_W-1:0]           res_w;
	logic                       res_at_limit;

	assign s_tready = (state_q == IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'(res_q);
	assign m_tuser  = sat_q;

	// Request decode: the magnitude of the full 5-bit range fits in 5 bits.
	assign angle_in = s_tdata[ANGLE_W-1:0];
	assign cnt_in   = s_tdata[ANGLE_W +: CNT_W];
	assign n_in     = (cnt_in > CNT_W'(MAX_TERMS - 1)) ? CNT_W'(MAX_TERMS - 1) : cnt_in;
	assign xneg_in  = angle_in[ANGLE_W-1];
	assign xmag_in  = xneg_in ? XMAG_W'(~angle_in + 1'b1) : XMAG_W'(angle_in);

	// Term i uses k = 2i for sine and k = 2i-1 for cosine.
	assign k_w = cosine_q ? K_W'({i_q, 1'b0} - 1'b1) : K_W'({i_q, 1'b0});

	// Long division, one byte of the dividend per digit step. The remainder of
	// the previous digit comes back through the multiplier as q*d.
	assign rem_w    = first_q ? '0 : D_W'(rprime_q - mul_p[RP_W-1:0]);
	assign rprime_w = {rem_w, div_q[{dig_q, 3'b000} +: DIGIT_W]};
	assign qd_w     = mul_p[RECIP_SHIFT +: DIGIT_W];
	assign mag_new  = quo_q[MAG_W-1:0];

	assign res_at_limit = (res_q == RES_MAX_S[RES_W-1:0]) || (res_q == RES_MIN_S[RES_W-1:0]);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			SETUP: begin
				mul_a = MUL_W'(mag_q[MUL_W-1:0]);
				mul_b = MUL_W'(x2_q);
			end
			MHI: begin
				mul_a = MUL_W'(mag_q[MAG_W-1:MUL_W]);
				mul_b = MUL_W'(x2_q);
			end
			DQ: begin
				mul_a = MUL_W'(rprime_w);
				mul_b = recip_q;
			end
			DR: begin
				mul_a = MUL_W'(qd_w);
				mul_b = MUL_W'(d_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	tsc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.a      (mul_a),
		.b      (mul_b),
		.p      (mul_p)
	);

	// Only the final sum is clamped to the result range.
	always_comb begin
		sum_hi = (sum_q > RES_MAX_S);
		sum_lo = (sum_q < RES_MIN_S);
		if (sum_hi) begin
			res_w = RES_MAX_S[RES_W-1:0];
		end else if (sum_lo) begin
			res_w = RES_MIN_S[RES_W-1:0];
		end else begin
			res_w = sum_q[RES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			m_valid_q <= 1'b0;
			cosine_q  <= 1'b0;
			x2_q      <= '0;
			mag_q     <= '0;
			neg_q     <= 1'b0;
			sum_q     <= '0;
			i_q       <= '0;
			n_q       <= '0;
			d_q       <= '0;
			recip_q   <= '0;
			plo_q     <= '0;
			div_q     <= '0;
			quo_q     <= '0;
			dig_q     <= '0;
			first_q   <= 1'b0;
			rprime_q  <= '0;
			res_q     <= '0;
			sat_q     <= 1'b0;
		end else begin
			// A result leaving while the next one is loaded keeps the flag set.
			if (m_valid_q && m_tready && state_q != DONE) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (s_accept) begin
						cosine_q <= s_tuser;
						x2_q     <= X2_W'(xmag_in * xmag_in);
						n_q      <= n_in;
						i_q      <= CNT_W'(1);
						if (s_tuser) begin
							mag_q <= MAG_W'(1) << FRAC_BITS;
							neg_q <= 1'b0;
							sum_q <= SUM_W'(1) <<< FRAC_BITS;
						end else begin
							mag_q <= MAG_W'(xmag_in) << FRAC_BITS;
							neg_q <= xneg_in;
							sum_q <= SUM_W'(angle_in) <<< FRAC_BITS;
						end
						state_q <= (n_in == '0) ? DONE : SETUP;
					end
				end
				SETUP: begin
					d_q     <= tsc_den(k_w);
					recip_q <= RECIP_TAB[k_w];
					state_q <= MHI;
				end
				MHI: begin
					plo_q   <= mul_p;
					state_q <= MSUM;
				end
				MSUM: begin
					// Dividend |t| * x^2 + d/2 rounds the quotient to nearest.
					div_q   <= DIV_W'(plo_q) + {mul_p[DIV_W-MUL_W-1:0], MUL_W'(0)}
						+ DIV_W'(d_q >> 1);
					dig_q   <= DIG_IDX_W'(NUM_DIGITS - 1);
					first_q <= 1'b1;
					state_q <= DQ;
				end
				DQ: begin
					rprime_q <= rprime_w;
					first_q  <= 1'b0;
					state_q  <= DR;
				end
				DR: begin
					quo_q <= {quo_q[DIV_W-DIGIT_W-1:0], qd_w};
					if (dig_q == '0) begin
						state_q <= ACC;
					end else begin
						dig_q   <= dig_q - 1'b1;
						state_q <= DQ;
					end
				end
				ACC: begin
					mag_q <= mag_new;
					if (mag_new == '0) begin
						neg_q <= 1'b0;
					end else begin
						neg_q <= !neg_q;
						if (neg_q) begin
							sum_q <= sum_q + SUM_W'(mag_new);
						end else begin
							sum_q <= sum_q - SUM_W'(mag_new);
						end
					end
					if (i_q == n_q) begin
						state_q <= DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= SETUP;
					end
				end
				DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						res_q     <= res_w;
						sat_q     <= sum_hi || sum_lo;
						state_q   <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// The sequencer is busy in the cycle after it takes a request.
	`TSC_ASSERT_NXT(a_busy_after_accept, s_accept, !s_tready)
	// Each digit remainder must stay below the divisor.
	`TSC_ASSERT_IMP(a_rem_below_den, state_q == DQ && !first_q, rem_w < d_q)
	// The reciprocal estimate of a digit always fits in one byte.
	`TSC_ASSERT_IMP(a_digit_fits, state_q == DR, mul_p[PROD_W-1:RECIP_SHIFT+DIGIT_W] == '0)
	// The term index never passes the last term while terms are being worked.
	`TSC_ASSERT_IMP(a_index_bound, state_q != IDLE && state_q != DONE, i_q <= n_q)
	// A clamped result is one of the two range limits.
	`TSC_ASSERT_IMP(a_sat_at_limit, m_valid_q && sat_q, res_at_limit)

endmodule

`default_nettype wire

// ===== tb/tb_taylor_sine_cosine_top.sv =====
// Testbench for taylor_sine_cosine_top: directed and random requests on the input stream,
// each result checked against its table sum or a bit-exact fixed-point Taylor partial sum.
// Depends on tsc_pkg and the taylor_sine_cosine_top RTL.

module tb_taylor_sine_cosine_top;

	import tsc_pkg::*;

	// The series select travels on s_tuser.
	typedef enum logic {
		OP_SINE   = 1'b0,
		OP_COSINE = 1'b1
	} series_e;

	// One expected or observed result: the clamped sum and its saturation flag.
	typedef struct packed {
		logic [RES_W-1:0] value;
		logic             clamped;
	} partial_sum_t;

	// A row of the directed table. When typed is set, the row carries its own
	// expected sum; otherwise the predictor supplies it.
	typedef struct {
		series_e                   op;
		logic signed [ANGLE_W-1:0] angle;
		logic [CNT_W-1:0]          terms;
		bit                        typed;
		longint                    sum;
		bit                        clamped;
	} request_row_t;

	localparam int     RESET_CYCLES    = 9;
	localparam int     RANDOM_REQUESTS = 1525;
	localparam int     DIRECTED_ROWS   = 25;
	localparam int     TOTAL_REQUESTS  = DIRECTED_ROWS + RANDOM_REQUESTS;
	// The final stretch of requests runs with both sides always ready.
	localparam int     CALM_TAIL       = 150;
	// Wait longer than the longest request (n = 15) takes after the last result,
	// so that any stray extra result would still be caught.
	localparam int     DRAIN_CYCLES    = 300;
	// The longest correct quiet stretch is the work of the longest request plus a
	// random gap on each side, and the drain wait above; this is several times that.
	localparam int     WATCHDOG_LIMIT  = 2000;
	localparam longint ONE_FIX         = longint'(1) << FRAC_BITS;
	localparam longint SUM_MAX         = (longint'(1) << (RES_W - 1)) - 1;
	localparam longint SUM_MIN         = -(longint'(1) << (RES_W - 1));

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	// Expected results, oldest first, one per accepted request.
	partial_sum_t pending_sums[$];

	// Cleared in quiet stretches and for the tail of the run so that stretches with
	// no idling at all are exercised too.
	bit idling_on = 1'b1;

	int failures      = 0;
	int accepted      = 0;
	int sine_requests = 0;
	int results_seen  = 0;
	int clamped_seen  = 0;

	// Directed requests. The rows with an obvious answer carry it: the first term
	// alone, a zero angle where every later term vanishes, and a quickly growing
	// sine series that is clamped at either end of the range. The other rows rely
	// on the predictor: the largest angles, the longest series and some mixed cases.
	request_row_t directed_rows [DIRECTED_ROWS] = '{
		'{OP_COSINE, 5'sd0,   4'd0,  1'b1, ONE_FIX,       1'b0},
		'{OP_COSINE, 5'sd0,   4'd15, 1'b1, ONE_FIX,       1'b0},
		'{OP_SINE,   5'sd0,   4'd0,  1'b1, 0,             1'b0},
		'{OP_SINE,   5'sd0,   4'd15, 1'b1, 0,             1'b0},
		'{OP_SINE,   5'sd1,   4'd0,  1'b1, ONE_FIX,       1'b0},
		'{OP_SINE,   -5'sd16, 4'd0,  1'b1, -16 * ONE_FIX, 1'b0},
		'{OP_SINE,   5'sd15,  4'd0,  1'b1, 15 * ONE_FIX,  1'b0},
		'{OP_COSINE, -5'sd16, 4'd0,  1'b1, ONE_FIX,       1'b0},
		'{OP_COSINE, 5'sd15,  4'd0,  1'b1, ONE_FIX,       1'b0},
		'{OP_SINE,   -5'sd16, 4'd2,  1'b1, SUM_MIN,       1'b1},
		'{OP_SINE,   5'sd15,  4'd2,  1'b1, SUM_MAX,       1'b1},
		'{OP_SINE,   -5'sd16, 4'd15, 1'b0, 0,             1'b0},
		'{OP_SINE,   5'sd15,  4'd15, 1'b0, 0,             1'b0},
		'{OP_COSINE, -5'sd16, 4'd15, 1'b0, 0,             1'b0},
		'{OP_COSINE, 5'sd15,  4'd15, 1'b0, 0,             1'b0},
		'{OP_SINE,   5'sd8,   4'd15, 1'b0, 0,             1'b0},
		'{OP_SINE,   -5'sd8,  4'd15, 1'b0, 0,             1'b0},
		'{OP_COSINE, 5'sd8,   4'd15, 1'b0, 0,             1'b0},
		'{OP_COSINE, -5'sd8,  4'd15, 1'b0, 0,             1'b0},
		'{OP_SINE,   5'sd1,   4'd1,  1'b0, 0,             1'b0},
		'{OP_COSINE, 5'sd1,   4'd1,  1'b0, 0,             1'b0},
		'{OP_SINE,   -5'sd1,  4'd7,  1'b0, 0,             1'b0},
		'{OP_COSINE, 5'sd3,   4'd10, 1'b0, 0,             1'b0},
		'{OP_COSINE, -5'sd16, 4'd1,  1'b0, 0,             1'b0},
		'{OP_SINE,   5'sd9,   4'd4,  1'b0, 0,             1'b0}
	};

	taylor_sine_cosine_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Partial sum of the series through term index terms. Every term is derived
	// from the previous magnitude times x^2, divided by k(k+1) with rounding to
	// nearest and ties away from zero; the sign alternates, and a term that has
	// rounded to zero stays zero and positive. The sum is exact in 64 bits and
	// only the final value is clamped to the result range.
	function automatic partial_sum_t taylor_partial_sum(input series_e op,
			input logic signed [ANGLE_W-1:0] angle, input logic [CNT_W-1:0] terms);
		longint          x;
		longint          total;
		longint unsigned xmag;
		longint unsigned x_sq;
		longint unsigned mag;
		longint unsigned last;
		longint unsigned i;
		longint unsigned k;
		longint unsigned den;
		bit              neg;
		partial_sum_t    r;
		x = angle;
		xmag = (x < 0) ? -x : x;
		x_sq = xmag * xmag;
		last = (terms > MAX_TERMS - 1) ? MAX_TERMS - 1 : terms;
		if (op == OP_COSINE) begin
			mag = ONE_FIX;
			neg = 1'b0;
		end else begin
			mag = xmag << FRAC_BITS;
			neg = (x < 0);
		end
		total = neg ? -longint'(mag) : longint'(mag);
		for (i = 1; i <= last; i++) begin
			k = (op == OP_COSINE) ? 2 * i - 1 : 2 * i;
			den = k * (k + 1);
			mag = (mag * x_sq + den / 2) / den;
			neg = (mag == 0) ? 1'b0 : !neg;
			total += neg ? -longint'(mag) : longint'(mag);
		end
		r.clamped = 1'b1;
		if (total > SUM_MAX) begin
			total = SUM_MAX;
		end else if (total < SUM_MIN) begin
			total = SUM_MIN;
		end else begin
			r.clamped = 1'b0;
		end
		r.value = total[RES_W-1:0];
		return r;
	endfunction

	// Presents one request, starting at a falling edge, and returns at the falling
	// edge after it was accepted. An optional random gap with s_tvalid low comes
	// first. The expectation is queued at the accepting edge, well before the
	// result can appear, so the queue order always matches the request order.
	task automatic send_request(input series_e op, input logic signed [ANGLE_W-1:0] angle,
			input logic [CNT_W-1:0] terms, input partial_sum_t want);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_DATA_W'({terms, angle});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_sums.push_back(want);
		accepted++;
		if (op == OP_SINE) sine_requests++;
		// Every fourth block of 120 requests, and the tail of the run, is calm.
		idling_on = (accepted < TOTAL_REQUESTS - CALM_TAIL) && ((accepted / 120) % 4 != 3);
		@(negedge clk);
	endtask

	// Receiver: stalls of random length at random times, each followed by a return
	// to ready. m_tready changes only at falling edges.
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && idling_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Result checker. Outputs are sampled at the rising edge, before the block's
	// registers take their new values.
	always @(posedge clk) begin
		partial_sum_t got;
		partial_sum_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.value   = m_tdata[RES_W-1:0];
			got.clamped = m_tuser;
			results_seen++;
			if (got.clamped) clamped_seen++;
			if (pending_sums.size() == 0) begin
				$error("result %0d arrived with no request outstanding", $signed(got.value));
				failures++;
			end else begin
				want = pending_sums.pop_front();
				if (got.value !== want.value) begin
					$error("result: expected %0d, got %0d",
						$signed(want.value), $signed(got.value));
					failures++;
				end
				if (got.clamped !== want.clamped) begin
					$error("saturated: expected %0b, got %0b", want.clamped, got.clamped);
					failures++;
				end
			end
		end
	end

	// Watchdog: ends the run when no request and no result has moved for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
			quiet, pending_sums.size());
		$display("tb_taylor_sine_cosine_top: errors");
		$finish;
	end

	// Main sequence: reset once, the directed table, then random requests.
	initial begin
		partial_sum_t              want;
		series_e                   op;
		logic signed [ANGLE_W-1:0] angle;
		logic [CNT_W-1:0]          terms;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].typed) begin
				want.value   = directed_rows[r].sum[RES_W-1:0];
				want.clamped = directed_rows[r].clamped;
			end else begin
				want = taylor_partial_sum(directed_rows[r].op, directed_rows[r].angle,
					directed_rows[r].terms);
			end
			send_request(directed_rows[r].op, directed_rows[r].angle,
				directed_rows[r].terms, want);
		end

		// Most angles stay in the nominal range -8..8; the rest use every 5-bit code.
		repeat (RANDOM_REQUESTS) begin
			op = $urandom_range(0, 1) ? OP_COSINE : OP_SINE;
			if ($urandom_range(0, 3) != 0) begin
				angle = ANGLE_W'($urandom_range(0, 16) - 8);
			end else begin
				angle = ANGLE_W'($urandom());
			end
			terms = CNT_W'($urandom_range(0, 15));
			send_request(op, angle, terms, taylor_partial_sum(op, angle, terms));
		end
		s_tvalid <= 1'b0;

		while (pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d sine, %0d cosine), term counts 0..15",
			accepted, sine_requests, accepted - sine_requests);
		$display("checked %0d results, %0d of them clamped to range", results_seen,
			clamped_seen);
		if (failures == 0) begin
			$display("tb_taylor_sine_cosine_top: clean");
		end else begin
			$display("tb_taylor_sine_cosine_top: errors");
		end
		$finish;
	end

endmodule
